/* rtl/tlet_pkg.sv */
// Package for the timed LED event table: sizes, field widths, operation and
// slot command codes, and the layout of one stored event.
// No dependencies; imported by timed_led_event_table_unit.
package tlet_pkg;

    localparam int EVENT_SLOTS = 16;
    localparam int LED_COUNT   = 64;
    localparam int TIME_BITS   = 32;
    localparam int MAX_RESULTS = 16;

    localparam int SLOT_W  = $clog2(EVENT_SLOTS);
    localparam int SCAN_W  = $clog2(EVENT_SLOTS + 1);
    localparam int CNT_W   = $clog2(MAX_RESULTS + 1);
    localparam int OP_W    = 2;
    localparam int LED_W   = 6;
    localparam int CODE_W  = 2;
    localparam int SLOTF_W = 4;
    localparam int WORD_W  = 24;
    localparam int CMDF_W  = 2;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_DELETE = 2'd1,
        OP_READ   = 2'd2,
        OP_TICK   = 2'd3
    } op_t;

    localparam logic [CMDF_W-1:0] CMD_EMPTY = 2'd0;
    localparam logic [CMDF_W-1:0] CMD_ON    = 2'd1;
    localparam logic [CMDF_W-1:0] CMD_OFF   = 2'd2;

    localparam logic [WORD_W-1:0] COLOR0_RESET = 24'hFFFFFF;
    localparam logic [WORD_W-1:0] COLOR1_RESET = 24'h00FF00;
    localparam logic [WORD_W-1:0] COLOR2_RESET = 24'hFF0000;
    localparam logic [WORD_W-1:0] COLOR3_RESET = 24'h0000FF;

    typedef struct packed {
        logic [LED_W-1:0]     led;
        logic [CODE_W-1:0]    color;
        logic [TIME_BITS-1:0] due;
    } slot_entry_t;

endpackage

/* rtl/timed_led_event_table_unit.sv */
// Timed LED event table: top level with the sequencer, the slot memory and
// the colour register file.
// Depends on tlet_pkg.
//
// Usage. Input transactions arrive on in_valid/in_ready with one field per
// port; operation selects add, delete, read or tick. Results leave on
// out_valid/out_ready through an output register, so a finished result may
// wait there while the next input transaction is already taken.
// Add, delete and read give exactly one result, which the execute state
// writes into the output register once it is free; the sequencer then
// returns to idle for the next input. A tick reads every slot from the
// slot memory, one slot a cycle, to mark the due events, then spends a
// fire and an emit state on each fired event: one memory read and one
// output transaction. A tick with nothing due gives a single result
// with fired low. The single read port of the slot memory paces the scan
// and the fired events. The last result of every input carries last high.
// Reset empties every slot and loads the default colour words; no clearing
// pass is needed since occupancy lives in flip-flops. When the receiver
// stalls, the sequencer holds in place and no result is dropped.
// Colour words must be written over the APB port while idle; the block does not enforce it.
module timed_led_event_table_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [tlet_pkg::OP_W-1:0]         operation,
    input  logic                              command,
    input  logic [tlet_pkg::LED_W-1:0]        led_index,
    input  logic [tlet_pkg::CODE_W-1:0]       color_code,
    input  logic [tlet_pkg::TIME_BITS-1:0]    event_time,
    input  logic [tlet_pkg::SLOTF_W-1:0]      slot_index,
    input  logic [tlet_pkg::TIME_BITS-1:0]    current_time,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              accepted,
    output logic [tlet_pkg::CMDF_W-1:0]       read_command,
    output logic [tlet_pkg::LED_W-1:0]        read_led,
    output logic [tlet_pkg::CODE_W-1:0]       read_color,
    output logic [tlet_pkg::TIME_BITS-1:0]    read_time,
    output logic                              fired,
    output logic [tlet_pkg::LED_W-1:0]        fired_led,
    output logic [tlet_pkg::WORD_W-1:0]       fired_color,
    output logic                              last,
    output logic                              any_free,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tlet_pkg::PADDR_W-1:0]      paddr,
    input  logic [tlet_pkg::PDATA_W-1:0]      pwdata,
    output logic [tlet_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);
    import tlet_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_DECIDE,
        S_FIRE,
        S_EMIT
    } state_t;

    // Colour register file.
    logic [WORD_W-1:0] color_reg [4];

    // Slot memory and its ports.
    slot_entry_t       slot_mem [EVENT_SLOTS];
    slot_entry_t       mem_rdata_reg;
    logic              mem_we;
    logic [SLOT_W-1:0] mem_waddr;
    slot_entry_t       mem_wdata;
    logic              mem_re;
    logic [SLOT_W-1:0] mem_raddr;

    // Sequencer state.
    state_t               state_reg, state_next;
    op_t                  op_reg, op_next;
    logic                 cmd_reg, cmd_next;
    logic [LED_W-1:0]     led_reg, led_next;
    logic [CODE_W-1:0]    code_reg, code_next;
    logic [TIME_BITS-1:0] etime_reg, etime_next;
    logic [SLOTF_W-1:0]   slot_reg, slot_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [EVENT_SLOTS-1:0] busy_reg, busy_next;
    logic [EVENT_SLOTS-1:0] off_reg, off_next;
    logic [EVENT_SLOTS-1:0] due_reg, due_next;
    logic [SCAN_W-1:0]    scan_idx_reg, scan_idx_next;
    logic                 chk_valid_reg, chk_valid_next;
    logic [SLOT_W-1:0]    chk_idx_reg, chk_idx_next;
    logic [CNT_W-1:0]     fire_cnt_reg, fire_cnt_next;
    logic [SLOT_W-1:0]    fire_idx_reg, fire_idx_next;

    // Output register.
    logic                 out_valid_reg, out_valid_next;
    logic                 accepted_reg, accepted_next;
    logic [CMDF_W-1:0]    rd_cmd_reg, rd_cmd_next;
    logic [LED_W-1:0]     rd_led_reg, rd_led_next;
    logic [CODE_W-1:0]    rd_color_reg, rd_color_next;
    logic [TIME_BITS-1:0] rd_time_reg, rd_time_next;
    logic                 fired_reg, fired_next;
    logic [LED_W-1:0]     f_led_reg, f_led_next;
    logic [WORD_W-1:0]    f_color_reg, f_color_next;
    logic                 last_reg, last_next;
    logic                 any_free_reg, any_free_next;

    logic                 out_free;
    logic                 cfg_write;
    logic [SLOT_W-1:0]    empty_idx;
    logic [SLOT_W-1:0]    due_idx;
    logic [EVENT_SLOTS-1:0] due_rest;

    function automatic logic [SLOT_W-1:0] lowest_set(input logic [EVENT_SLOTS-1:0] flags);
        logic [SLOT_W-1:0] idx;
        idx = '0;
        for (int i = EVENT_SLOTS - 1; i >= 0; i--)
        begin
            if (flags[i])
            begin
                idx = SLOT_W'(i);
            end
        end
        return idx;
    endfunction

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = {{(PDATA_W - WORD_W){1'b0}}, color_reg[paddr[3:2]]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg[0] <= COLOR0_RESET;
            color_reg[1] <= COLOR1_RESET;
            color_reg[2] <= COLOR2_RESET;
            color_reg[3] <= COLOR3_RESET;
        end
        else if (cfg_write)
        begin
            color_reg[paddr[3:2]] <= pwdata[WORD_W-1:0];
        end
    end

    // Slot memory: one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= slot_mem[mem_raddr];
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || out_ready;
    assign empty_idx = lowest_set(~busy_reg);
    assign due_idx   = lowest_set(due_reg);
    assign due_rest  = due_reg & ~(EVENT_SLOTS'(1) << fire_idx_reg);

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        cmd_next       = cmd_reg;
        led_next       = led_reg;
        code_next      = code_reg;
        etime_next     = etime_reg;
        slot_next      = slot_reg;
        now_next       = now_reg;
        busy_next      = busy_reg;
        off_next       = off_reg;
        due_next       = due_reg;
        scan_idx_next  = scan_idx_reg;
        chk_valid_next = chk_valid_reg;
        chk_idx_next   = chk_idx_reg;
        fire_cnt_next  = fire_cnt_reg;
        fire_idx_next  = fire_idx_reg;

        out_valid_next = out_valid_reg && !out_ready;
        accepted_next  = accepted_reg;
        rd_cmd_next    = rd_cmd_reg;
        rd_led_next    = rd_led_reg;
        rd_color_next  = rd_color_reg;
        rd_time_next   = rd_time_reg;
        fired_next     = fired_reg;
        f_led_next     = f_led_reg;
        f_color_next   = f_color_reg;
        last_next      = last_reg;
        any_free_next  = any_free_reg;

        mem_we    = 1'b0;
        mem_waddr = empty_idx;
        mem_wdata = '{led: led_reg, color: code_reg, due: etime_reg};
        mem_re    = 1'b0;
        mem_raddr = slot_index[SLOT_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = op_t'(operation);
                    cmd_next   = command;
                    led_next   = led_index;
                    code_next  = color_code;
                    etime_next = event_time;
                    slot_next  = slot_index;
                    now_next   = current_time;
                    if (op_t'(operation) == OP_TICK)
                    begin
                        scan_idx_next  = '0;
                        chk_valid_next = 1'b0;
                        due_next       = '0;
                        fire_cnt_next  = '0;
                        state_next     = S_SCAN;
                    end
                    else
                    begin
                        // A read fetches its slot now; the data waits in the read register.
                        mem_re     = (op_t'(operation) == OP_READ);
                        state_next = S_EXEC;
                    end
                end
            end

            S_EXEC:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    accepted_next  = 1'b0;
                    rd_cmd_next    = CMD_EMPTY;
                    rd_led_next    = '0;
                    rd_color_next  = '0;
                    rd_time_next   = '0;
                    fired_next     = 1'b0;
                    f_led_next     = '0;
                    f_color_next   = '0;
                    last_next      = 1'b1;
                    case (op_reg)
                        OP_ADD:
                        begin
                            if (!(&busy_reg) && (32'(led_reg) < LED_COUNT))
                            begin
                                busy_next[empty_idx] = 1'b1;
                                off_next[empty_idx]  = cmd_reg;
                                mem_we               = 1'b1;
                                accepted_next        = 1'b1;
                            end
                        end
                        OP_DELETE:
                        begin
                            if ((32'(slot_reg) < EVENT_SLOTS) && busy_reg[slot_reg[SLOT_W-1:0]])
                            begin
                                busy_next[slot_reg[SLOT_W-1:0]] = 1'b0;
                                accepted_next                   = 1'b1;
                            end
                        end
                        OP_READ:
                        begin
                            if ((32'(slot_reg) < EVENT_SLOTS) && busy_reg[slot_reg[SLOT_W-1:0]])
                            begin
                                accepted_next = 1'b1;
                                rd_cmd_next   = off_reg[slot_reg[SLOT_W-1:0]] ? CMD_OFF : CMD_ON;
                                rd_led_next   = mem_rdata_reg.led;
                                rd_color_next = mem_rdata_reg.color;
                                rd_time_next  = mem_rdata_reg.due;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    any_free_next = !(&busy_next);
                    state_next    = S_IDLE;
                end
            end

            S_SCAN:
            begin
                // Read one slot a cycle; its due time is compared once the read register holds it.
                if (scan_idx_reg < SCAN_W'(EVENT_SLOTS))
                begin
                    mem_re         = 1'b1;
                    mem_raddr      = scan_idx_reg[SLOT_W-1:0];
                    scan_idx_next  = scan_idx_reg + SCAN_W'(1);
                    chk_valid_next = 1'b1;
                    chk_idx_next   = scan_idx_reg[SLOT_W-1:0];
                end
                else
                begin
                    chk_valid_next = 1'b0;
                end
                if (chk_valid_reg && busy_reg[chk_idx_reg] && (now_reg > mem_rdata_reg.due)
                    && (fire_cnt_reg < CNT_W'(MAX_RESULTS)))
                begin
                    due_next[chk_idx_reg] = 1'b1;
                    fire_cnt_next         = fire_cnt_reg + CNT_W'(1);
                end
                if ((scan_idx_reg == SCAN_W'(EVENT_SLOTS)) && !chk_valid_reg)
                begin
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                if (|due_reg)
                begin
                    state_next = S_FIRE;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    accepted_next  = 1'b0;
                    rd_cmd_next    = CMD_EMPTY;
                    rd_led_next    = '0;
                    rd_color_next  = '0;
                    rd_time_next   = '0;
                    fired_next     = 1'b0;
                    f_led_next     = '0;
                    f_color_next   = '0;
                    last_next      = 1'b1;
                    any_free_next  = !(&busy_reg);
                    state_next     = S_IDLE;
                end
            end

            S_FIRE:
            begin
                mem_re        = 1'b1;
                mem_raddr     = due_idx;
                fire_idx_next = due_idx;
                state_next    = S_EMIT;
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    accepted_next  = 1'b0;
                    rd_cmd_next    = CMD_EMPTY;
                    rd_led_next    = '0;
                    rd_color_next  = '0;
                    rd_time_next   = '0;
                    fired_next     = 1'b1;
                    f_led_next     = mem_rdata_reg.led;
                    f_color_next   = off_reg[fire_idx_reg] ? '0 : color_reg[mem_rdata_reg.color];
                    last_next      = (due_rest == '0);
                    // Slots still busy once every due event has fired stay busy.
                    any_free_next  = !(&(busy_reg & ~due_reg));
                    busy_next[fire_idx_reg] = 1'b0;
                    due_next[fire_idx_reg]  = 1'b0;
                    state_next     = (due_rest == '0) ? S_IDLE : S_FIRE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            busy_reg      <= '0;
            off_reg       <= '0;
            due_reg       <= '0;
            scan_idx_reg  <= '0;
            chk_valid_reg <= 1'b0;
            chk_idx_reg   <= '0;
            fire_cnt_reg  <= '0;
            fire_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            busy_reg      <= busy_next;
            off_reg       <= off_next;
            due_reg       <= due_next;
            scan_idx_reg  <= scan_idx_next;
            chk_valid_reg <= chk_valid_next;
            chk_idx_reg   <= chk_idx_next;
            fire_cnt_reg  <= fire_cnt_next;
            fire_idx_reg  <= fire_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        cmd_reg      <= cmd_next;
        led_reg      <= led_next;
        code_reg     <= code_next;
        etime_reg    <= etime_next;
        slot_reg     <= slot_next;
        now_reg      <= now_next;
        accepted_reg <= accepted_next;
        rd_cmd_reg   <= rd_cmd_next;
        rd_led_reg   <= rd_led_next;
        rd_color_reg <= rd_color_next;
        rd_time_reg  <= rd_time_next;
        fired_reg    <= fired_next;
        f_led_reg    <= f_led_next;
        f_color_reg  <= f_color_next;
        last_reg     <= last_next;
        any_free_reg <= any_free_next;
    end

    assign out_valid    = out_valid_reg;
    assign accepted     = accepted_reg;
    assign read_command = rd_cmd_reg;
    assign read_led     = rd_led_reg;
    assign read_color   = rd_color_reg;
    assign read_time    = rd_time_reg;
    assign fired        = fired_reg;
    assign fired_led    = f_led_reg;
    assign fired_color  = f_color_reg;
    assign last         = last_reg;
    assign any_free     = any_free_reg;

endmodule
